FILE: design/glyph_outline_point_decoder_macros.svh
// Assertion macros for the glyph outline point decoder checker.
// Depends on nothing; included by the checker file.
`ifndef GLYPH_OUTLINE_POINT_DECODER_MACROS_SVH
`define GLYPH_OUTLINE_POINT_DECODER_MACROS_SVH
// Plain implication check clocked on clk, disabled in reset.
`define GOPD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check.
`define GOPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/gopd_pkg.sv
// Package for the glyph outline point decoder: phases, codes, flag bits.
// Used by the front end, back end, top level and checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gopd_pkg;
  localparam int unsigned MaxPointsDefault   = 1024;
  localparam int unsigned MaxContoursDefault = 256;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0, PH_ENDS = 4'd1, PH_INSLEN = 4'd2, PH_SKIP = 4'd3,
    PH_FLAGS = 4'd4, PH_XS = 4'd5, PH_YS = 4'd6, PH_DONE = 4'd7, PH_ERR = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0, MODE_ADV = 2'd1, MODE_START = 2'd2, MODE_BAD = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_COMPOSITE = 3'd1, ERR_ENDS = 3'd2, ERR_POINTS = 3'd3,
    ERR_TRUNC = 3'd4, ERR_MISPLACED = 3'd5
  } err_t;

  localparam int unsigned FB_ON = 0;
  localparam int unsigned FB_XS = 1;
  localparam int unsigned FB_YS = 2;
  localparam int unsigned FB_XP = 3;
  localparam int unsigned FB_YP = 4;
  localparam logic [7:0] RAW_REPEAT = 8'h08;

  // One queued input transaction.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       byte_last;
  } item_t;

  // One result.
  typedef struct packed {
    logic        point_valid;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        curve_point;
    logic        contour_end;
    logic        point_last;
    logic        wants_byte;
    logic        glyph_done;
    logic [2:0]  error_code;
  } result_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic s;
    s = v[31];
    if (!s && v[30:15] != 16'h0000) sat16 = 16'h7fff;
    else if (s && v[30:15] != 16'hffff) sat16 = 16'h8000;
    else sat16 = v[15:0];
  endfunction
endpackage
`default_nettype wire

FILE: design/gopd_ram.sv
// Generic single-port-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gopd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/gopd_front.sv
// Front end: accepts input transactions into a two-entry queue.
// Depends on gopd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gopd_front import gopd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  output logic       q_valid,
  output item_t      q_item,
  input  wire logic  q_take
);
  item_t ent [2];
  logic  rd, wr;
  logic [1:0] cnt;
  logic  push, pop;

  assign in_stall = cnt == 2'd2;
  assign push = in_valid && !in_stall;
  assign pop = q_valid && q_take;
  assign q_valid = cnt != 2'd0;
  assign q_item = ent[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0; wr <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wr <= !wr;
      if (pop) rd <= !rd;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (push) ent[wr] <= in_item;
  end
endmodule
`default_nettype wire

FILE: design/gopd_back.sv
// Back end: runs the glyph parse, one queued transaction per cycle while the result is not stalled.
// Depends on gopd_pkg and gopd_ram.
`timescale 1ns / 1ps
`default_nettype none
module gopd_back import gopd_pkg::*; #(
  parameter int unsigned POINT_LIMIT  = MaxPointsDefault,
  parameter int unsigned MAX_CONTOURS = MaxContoursDefault
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire item_t q_item,
  output logic       q_take,
  output logic       res_valid,
  output result_t    res,
  input  wire logic  res_stall
);
  localparam int unsigned PW = POINT_LIMIT > 1 ? $clog2(POINT_LIMIT) : 1;
  localparam int unsigned CW = MAX_CONTOURS > 1 ? $clog2(MAX_CONTOURS) : 1;
  localparam int unsigned PD = 1 << PW;
  localparam int unsigned CD = 1 << CW;

  phase_t      phase, phase_next;
  logic [3:0]  bif, bif_next;
  logic [7:0]  held, held_next;
  logic [15:0] ctot, ctot_next, cptr, cptr_next;
  logic [16:0] ptot, ptot_next;
  logic [15:0] pptr, pptr_next;
  logic [7:0]  rep, rep_next;
  logic [15:0] skip, skip_next;
  logic [31:0] sum, sum_next;
  logic [2:0]  err, err_next;
  logic        ended, ended_next;
  logic [15:0] last_end, last_end_next;

  // Stores read by pointer; the read address is the next pointer so data is
  // ready the cycle the pointer reaches it.
  logic        f_we, x_we, c_we;
  logic [4:0]  f_wd, f_rd;
  logic [15:0] x_wd, x_rd, c_wd, c_rd;
  logic [PW-1:0] f_wa, x_wa;
  logic [CW-1:0] c_wa;

  function automatic logic [PW-1:0] pidx(input logic [16:0] i);
    if (i >= 17'(POINT_LIMIT)) pidx = PW'(POINT_LIMIT - 1);
    else pidx = i[PW-1:0];
  endfunction
  function automatic logic [CW-1:0] cidx(input logic [15:0] i);
    if (i >= 16'(MAX_CONTOURS)) cidx = CW'(MAX_CONTOURS - 1);
    else cidx = i[CW-1:0];
  endfunction

  gopd_ram #(.WIDTH(5), .DEPTH(PD)) u_flags (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd),
    .raddr(pidx({1'b0, pptr_next})), .rdata(f_rd));
  gopd_ram #(.WIDTH(16), .DEPTH(PD)) u_xs (
    .clk, .we(x_we), .waddr(x_wa), .wdata(x_wd),
    .raddr(pidx({1'b0, pptr_next})), .rdata(x_rd));
  gopd_ram #(.WIDTH(16), .DEPTH(CD)) u_ends (
    .clk, .we(c_we), .waddr(c_wa), .wdata(c_wd),
    .raddr(cidx(cptr_next)), .rdata(c_rd));

  // A flag or x value written this cycle at the current pointer may be read next; bypass.
  logic       f_byp, x_byp;
  logic [4:0] f_bypd;
  logic [15:0] x_bypd;
  logic [4:0] fcur;
  logic [15:0] xcur;
  assign fcur = f_byp ? f_bypd : f_rd;
  assign xcur = x_byp ? x_bypd : x_rd;

  logic   step, ovalid;
  result_t o, ores;
  assign q_take = !(ovalid && res_stall);
  assign step = q_valid && q_take;
  assign res_valid = ovalid;

  function automatic logic [1:0] kind(input logic [4:0] f, input logic y);
    logic sh, sp;
    sh = y ? f[FB_YS] : f[FB_XS];
    sp = y ? f[FB_YP] : f[FB_XP];
    kind = sh ? 2'd1 : (sp ? 2'd0 : 2'd2);
  endfunction

  logic [7:0] b;
  logic [15:0] word;
  logic [4:0] fconv;
  assign b = q_item.data_byte;
  assign word = {held, b};
  assign fconv = {b[5], b[4], b[2], b[1], b[0]};

  // Need for a byte, judged on the current state. The flag at the pointer is
  // already read out, so this also serves the result of the last step.
  logic       need, live, trunc, sp;
  logic [1:0] k;
  assign k = kind(fcur, phase == PH_YS);
  assign sp = phase == PH_YS ? fcur[FB_YP] : fcur[FB_XP];
  always_comb begin
    case (phase)
      PH_HEADER, PH_ENDS, PH_INSLEN, PH_SKIP: need = 1'b1;
      PH_FLAGS: need = rep == 8'd0;
      PH_XS, PH_YS: need = k != 2'd0;
      default: need = 1'b0;
    endcase
  end
  assign live = phase != PH_ERR && phase != PH_DONE;
  // The record has ended but a byte is still wanted: truncated.
  assign trunc = live && ended && need;

  always_comb begin
    logic hb;
    logic [31:0] d;
    logic [16:0] left;
    phase_next = phase; bif_next = bif; held_next = held; ctot_next = ctot;
    cptr_next = cptr; ptot_next = ptot; pptr_next = pptr; rep_next = rep;
    skip_next = skip; sum_next = sum; err_next = err; ended_next = ended;
    last_end_next = last_end;
    f_we = 1'b0; f_wa = pidx({1'b0, pptr}); f_wd = fconv;
    x_we = 1'b0; x_wa = pidx({1'b0, pptr}); x_wd = sat16(sum);
    c_we = 1'b0; c_wa = cidx(cptr); c_wd = word;
    o = '0;
    hb = 1'b0; d = '0; left = '0;
    if (step) begin
      if (q_item.mode == MODE_START) begin
        phase_next = PH_HEADER; bif_next = '0; held_next = '0; ctot_next = '0;
        cptr_next = '0; ptot_next = '0; pptr_next = '0; rep_next = '0;
        skip_next = '0; sum_next = '0; err_next = ERR_NONE; ended_next = 1'b0;
        o.wants_byte = 1'b1;
      end else if (trunc) begin
        err_next = ERR_TRUNC; phase_next = PH_ERR;
      end else if (live) begin
        if (q_item.mode == MODE_BAD || ((q_item.mode == MODE_BYTE) != need)) begin
          err_next = ERR_MISPLACED; phase_next = PH_ERR;
        end else begin
          hb = q_item.mode == MODE_BYTE;
          if (hb && q_item.byte_last) ended_next = 1'b1;
          case (phase)
            PH_HEADER: begin
              if (bif == 4'd0) begin
                held_next = b; bif_next = bif + 4'd1;
              end else if (bif == 4'd1) begin
                if (held[7]) begin
                  err_next = ERR_COMPOSITE; phase_next = PH_ERR;
                end else if (word > 16'(MAX_CONTOURS)) begin
                  ctot_next = word; err_next = ERR_POINTS; phase_next = PH_ERR;
                end else begin
                  ctot_next = word; bif_next = bif + 4'd1;
                end
              end else if (bif == 4'd9) begin
                bif_next = '0; ptot_next = '0; cptr_next = '0;
                phase_next = ctot != 16'd0 ? PH_ENDS : PH_INSLEN;
              end else bif_next = bif + 4'd1;
            end
            PH_ENDS: begin
              if (bif == 4'd0) begin
                held_next = b; bif_next = 4'd1;
              end else begin
                bif_next = '0;
                if (cptr != 16'd0 && word <= last_end) begin
                  err_next = ERR_ENDS; phase_next = PH_ERR;
                end else begin
                  c_we = 1'b1; last_end_next = word;
                  cptr_next = cptr + 16'd1;
                  if (cptr + 16'd1 >= ctot) begin
                    ptot_next = {1'b0, word} + 17'd1; cptr_next = '0;
                    if ({1'b0, word} + 17'd1 > 17'(POINT_LIMIT)) begin
                      err_next = ERR_POINTS; phase_next = PH_ERR;
                    end else phase_next = PH_INSLEN;
                  end
                end
              end
            end
            PH_INSLEN: begin
              if (bif == 4'd0) begin
                held_next = b; bif_next = 4'd1;
              end else begin
                bif_next = '0; skip_next = word;
                if (word != 16'd0) phase_next = PH_SKIP;
                else begin
                  pptr_next = '0; rep_next = '0;
                  phase_next = ptot == 17'd0 ? PH_DONE : PH_FLAGS;
                end
              end
            end
            PH_SKIP: begin
              skip_next = skip - 16'd1;
              if (skip == 16'd1) begin
                bif_next = '0; pptr_next = '0; rep_next = '0;
                phase_next = ptot == 17'd0 ? PH_DONE : PH_FLAGS;
              end
            end
            PH_FLAGS: begin
              if (hb && bif == 4'd1) begin
                left = ptot - {1'b0, pptr};
                rep_next = {9'd0, b} < left ? b : left[7:0];
                bif_next = '0;
              end else begin
                f_wd = hb ? fconv : {held[5], held[4], held[2], held[1], held[0]};
                if ({1'b0, pptr} < ptot) begin
                  f_we = 1'b1; pptr_next = pptr + 16'd1;
                end
                if (hb && (b & RAW_REPEAT) != 8'd0) begin
                  held_next = b; bif_next = 4'd1;
                end
                if (!hb) rep_next = rep - 8'd1;
              end
              if (rep_next == 8'd0 && bif_next == 4'd0 && {1'b0, pptr_next} >= ptot) begin
                phase_next = PH_XS; pptr_next = '0; sum_next = '0;
              end
            end
            default: begin
              if (hb && k == 2'd2 && bif == 4'd0) begin
                held_next = b; bif_next = 4'd1;
              end else begin
                if (hb && k == 2'd1) d = sp ? {24'd0, b} : -{24'd0, b};
                else if (hb) begin
                  d = {{16{word[15]}}, word}; bif_next = '0;
                end
                sum_next = sum + d;
                if (phase == PH_XS) begin
                  x_we = 1'b1; x_wd = sat16(sum_next);
                  pptr_next = pptr + 16'd1;
                  if ({1'b0, pptr_next} >= ptot) begin
                    phase_next = PH_YS; pptr_next = '0; sum_next = '0; cptr_next = '0;
                  end
                end else begin
                  o.point_valid = 1'b1; o.point_x = xcur; o.point_y = sat16(sum_next);
                  o.curve_point = fcur[FB_ON];
                  if (cptr < ctot && cptr < 16'(MAX_CONTOURS) && c_rd == pptr) begin
                    o.contour_end = 1'b1; cptr_next = cptr + 16'd1;
                  end
                  if ({1'b0, pptr} + 17'd1 >= ptot) begin
                    o.point_last = 1'b1; phase_next = PH_DONE;
                  end
                  pptr_next = pptr + 16'd1;
                end
              end
            end
          endcase
        end
      end
      o.glyph_done = phase_next == PH_DONE;
      o.error_code = err_next;
    end
  end

  // Wants-byte and the truncation code follow the state left by the step.
  always_comb begin
    res = ores;
    res.wants_byte = live && need && !trunc;
    res.error_code = trunc ? ERR_TRUNC : ores.error_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER; bif <= '0; held <= '0; ctot <= '0; cptr <= '0;
      ptot <= '0; pptr <= '0; rep <= '0; skip <= '0; sum <= '0;
      err <= ERR_NONE; ended <= 1'b0; ovalid <= 1'b0; last_end <= '0;
      f_byp <= 1'b0; x_byp <= 1'b0;
    end else begin
      phase <= phase_next; bif <= bif_next; held <= held_next; ctot <= ctot_next;
      cptr <= cptr_next; ptot <= ptot_next; pptr <= pptr_next; rep <= rep_next;
      skip <= skip_next; sum <= sum_next; err <= err_next; ended <= ended_next;
      last_end <= last_end_next;
      if (step) ovalid <= 1'b1;
      else if (!res_stall) ovalid <= 1'b0;
      f_byp <= f_we && f_wa == pidx({1'b0, pptr_next});
      x_byp <= x_we && x_wa == pidx({1'b0, pptr_next});
    end
    f_bypd <= f_wd;
    x_bypd <= x_wd;
    if (step) ores <= o;
  end
endmodule
`default_nettype wire

FILE: design/glyph_outline_point_decoder.sv
// Top level of the glyph outline point decoder.
// Depends on gopd_pkg, gopd_front, gopd_back and gopd_ram.
`timescale 1ns / 1ps
`default_nettype none
// Decodes one simple-glyph record of a TrueType glyf table, one input
// transaction per cycle while no result is stalled. Each transaction (glyph
// byte, advance, or start of a new glyph) yields exactly one result,
// registered behind the back end after the queue entry and the parse step.
// Sustained rate is one transaction per clock while no result is stalled,
// limited by the parse step and one access per store. A two-entry queue parts
// the input handshake from the parser; while a result waits under stall the
// parser holds and the queue absorbs up to two more transactions. Point flags
// and x values live in RAMs of POINT_LIMIT entries rounded up to a power of
// two, contour ends in one of MAX_CONTOURS entries rounded up likewise; no
// clearing pass is needed since only entries of the current glyph are read.
module glyph_outline_point_decoder import gopd_pkg::*; #(
  parameter int unsigned POINT_LIMIT  = MaxPointsDefault,
  parameter int unsigned MAX_CONTOURS = MaxContoursDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             point_valid,
  output logic signed [15:0] point_x,
  output logic signed [15:0] point_y,
  output logic             curve_point,
  output logic             contour_end,
  output logic             point_last,
  output logic             wants_byte,
  output logic             glyph_done,
  output logic [2:0]       error_code
);
  item_t   in_item, q_item;
  logic    q_valid, q_take;
  result_t res;

  assign in_item = '{mode: mode, data_byte: data_byte, byte_last: byte_last};

  // Hold incoming transactions until the parser takes them.
  gopd_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .q_valid, .q_item, .q_take);

  // Advance the parse and register one result per transaction.
  gopd_back #(.POINT_LIMIT(POINT_LIMIT), .MAX_CONTOURS(MAX_CONTOURS)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_take,
    .res_valid(out_valid), .res, .res_stall(out_stall));

  assign point_valid = res.point_valid;
  assign point_x     = res.point_x;
  assign point_y     = res.point_y;
  assign curve_point = res.curve_point;
  assign contour_end = res.contour_end;
  assign point_last  = res.point_last;
  assign wants_byte  = res.wants_byte;
  assign glyph_done  = res.glyph_done;
  assign error_code  = res.error_code;
endmodule
`default_nettype wire

FILE: design/gopd_checker.sv
// Port-level checker for the glyph outline point decoder, bound to the top.
// Depends on gopd_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_outline_point_decoder_macros.svh"
module gopd_checker import gopd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        point_valid,
  input wire logic        point_last,
  input wire logic        contour_end,
  input wire logic        glyph_done,
  input wire logic        wants_byte,
  input wire logic [2:0]  error_code
);
  `GOPD_ASSERT(a_last_closes, out_valid && point_last, contour_end && glyph_done, "last point must close contour")
  `GOPD_ASSERT(a_err_quiet, out_valid && error_code != ERR_NONE, !wants_byte && !glyph_done, "error result wants more")
  `GOPD_ASSERT(a_done_quiet, out_valid && glyph_done, !wants_byte, "done result wants a byte")
  `GOPD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(point_last), "stalled result changed")
endmodule
bind glyph_outline_point_decoder gopd_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .point_valid, .point_last,
  .contour_end, .glyph_done, .wants_byte, .error_code);
`default_nettype wire
